// ----- rtl/tec_pkg.sv -----
// Shared types and constants for the tab expand and compress block.
`default_nettype none

package tec_pkg;

  localparam int unsigned TAB_MAX_DEF  = 16;
  localparam int unsigned QDEPTH_DEF   = 4;
  localparam int unsigned START_W      = 12;
  localparam int unsigned START_STEPS  = START_W;

  localparam logic [15:0] CH_TAB   = 16'h0009;
  localparam logic [15:0] CH_SPACE = 16'h0020;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_LEAD  = 2'd1,
    REG_TABW  = 2'd2,
    REG_START = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic                 we;
    reg_idx_e             idx;
    logic [START_W-1:0]   data;
  } cfg_wr_t;

  // One command per item: a run of spaces, then an optional final character.
  typedef struct packed {
    logic [4:0]  spaces;
    logic        has_fin;
    logic [15:0] fin_char;
    logic        last;
  } tec_cmd_t;

  localparam int unsigned CMD_W = $bits(tec_cmd_t);

endpackage

`default_nettype wire

// ----- rtl/tab_expand_compress_top.sv -----
// Top level of the tab expand and compress block.
// An item passes the command queue and the back end's command register; its first output
// beat is then registered. Throughput: one input beat per cycle while the output side keeps
// up; an n-beat item holds the back end until its last beat is taken, and the queue absorbs
// the difference. A register write holds off input while start column mod tab width is
// recomputed one bit a cycle. Reset loads the register defaults and empties the queue.
`default_nettype none

module tab_expand_compress_top #(
  parameter int unsigned TAB_MAX = tec_pkg::TAB_MAX_DEF,
  parameter int unsigned QDEPTH  = tec_pkg::QDEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [11:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] char_in
  input  wire logic        s_axis_tlast,   // line_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [15:0] char_out
  output logic             m_axis_tlast    // last_out
);

  tec_pkg::cfg_wr_t  cfg;
  tec_pkg::tec_cmd_t push_cmd, pop_cmd;
  logic              push, full, pop, empty;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = tec_pkg::reg_idx_e'(cfg_idx_i);
  assign cfg.data = cfg_data_i;

  tec_front #(
    .TAB_MAX(TAB_MAX)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .char_i     (s_axis_tdata),
    .line_end_i (s_axis_tlast),
    .q_full_i   (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  tec_fifo #(
    .DEPTH(QDEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (pop_cmd),
    .empty_o (empty)
  );

  tec_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_data_i    (pop_cmd),
    .q_empty_i   (empty),
    .q_pop_o     (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ----- rtl/tec_front.sv -----
// Front end: configuration registers, line state and per-character classification.
`default_nettype none

module tec_front #(
  parameter int unsigned TAB_MAX = tec_pkg::TAB_MAX_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire tec_pkg::cfg_wr_t cfg_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [15:0]      char_i,
  input  wire logic             line_end_i,
  input  wire logic             q_full_i,
  output logic                  push_o,
  output tec_pkg::tec_cmd_t     cmd_o
);

  localparam int unsigned TW_BOUND = (TAB_MAX < 16) ? TAB_MAX : 16;
  localparam int unsigned CNT_W    = $clog2(tec_pkg::START_STEPS);

  logic                        mode_q, lead_only_q;
  logic [4:0]                  tab_width_q;
  logic [tec_pkg::START_W-1:0] start_col_q;

  logic [3:0] phase_q, phase_d;
  logic [3:0] pend_q, pend_d;
  logic       lead_done_q, lead_done_d;
  logic [3:0] start_phase_q;

  logic                        busy_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [tec_pkg::START_W-1:0] dvd_q;
  logic [3:0]                  rem_q;

  logic [4:0] tw_eff;
  logic [4:0] adv5, pend_inc, rem_try, rem_next;
  logic [3:0] phase_adv;
  logic       accept, active;
  tec_pkg::tec_cmd_t cmd;

  always_comb begin
    if (tab_width_q == 5'd0) begin
      tw_eff = 5'd1;
    end else if (tab_width_q > 5'(TW_BOUND)) begin
      tw_eff = 5'(TW_BOUND);
    end else begin
      tw_eff = tab_width_q;
    end
  end

  assign adv5      = {1'b0, phase_q} + 5'd1;
  assign phase_adv = (adv5 >= tw_eff) ? 4'd0 : adv5[3:0];
  assign pend_inc  = {1'b0, pend_q} + 5'd1;
  assign active    = !(lead_only_q && lead_done_q);

  assign in_ready_o = !q_full_i && !busy_q;
  assign accept     = in_valid_i && in_ready_o;

  // Restoring remainder step for start column modulo tab width.
  assign rem_try  = {rem_q, dvd_q[tec_pkg::START_W-1]};
  assign rem_next = (rem_try >= tw_eff) ? (rem_try - tw_eff) : rem_try;

  always_comb begin
    cmd         = '0;
    phase_d     = phase_q;
    pend_d      = pend_q;
    lead_done_d = lead_done_q;
    if (!active) begin
      cmd.has_fin  = 1'b1;
      cmd.fin_char = char_i;
      phase_d      = (char_i == tec_pkg::CH_TAB) ? 4'd0 : phase_adv;
    end else if (char_i == tec_pkg::CH_TAB) begin
      if (!mode_q) begin
        cmd.spaces = tw_eff - {1'b0, phase_q};
      end else begin
        cmd.has_fin  = 1'b1;
        cmd.fin_char = tec_pkg::CH_TAB;
      end
      phase_d = 4'd0;
      pend_d  = 4'd0;
    end else if (char_i == tec_pkg::CH_SPACE) begin
      phase_d = phase_adv;
      if (!mode_q) begin
        cmd.has_fin  = 1'b1;
        cmd.fin_char = tec_pkg::CH_SPACE;
      end else if (phase_adv == 4'd0) begin
        cmd.has_fin  = 1'b1;
        cmd.fin_char = tec_pkg::CH_TAB;
        pend_d       = 4'd0;
      end else begin
        pend_d = pend_inc[3:0];
      end
    end else begin
      cmd.spaces   = {1'b0, pend_q};
      cmd.has_fin  = 1'b1;
      cmd.fin_char = char_i;
      phase_d      = phase_adv;
      pend_d       = 4'd0;
      if (lead_only_q) begin
        lead_done_d = 1'b1;
      end
    end
    // At line end any held spaces go out after whatever this character gave.
    if (line_end_i) begin
      cmd.spaces  = cmd.spaces + {1'b0, pend_d};
      cmd.last    = 1'b1;
      pend_d      = 4'd0;
      lead_done_d = 1'b0;
      phase_d     = start_phase_q;
    end
  end

  assign push_o = accept && ((cmd.spaces != 5'd0) || cmd.has_fin);
  assign cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= 1'b0;
      lead_only_q   <= 1'b0;
      tab_width_q   <= 5'd4;
      start_col_q   <= '0;
      phase_q       <= 4'd0;
      pend_q        <= 4'd0;
      lead_done_q   <= 1'b0;
      start_phase_q <= 4'd0;
      busy_q        <= 1'b0;
      cnt_q         <= '0;
      dvd_q         <= '0;
      rem_q         <= 4'd0;
    end else if (cfg_i.we) begin
      case (cfg_i.idx)
        tec_pkg::REG_MODE:  mode_q      <= cfg_i.data[0];
        tec_pkg::REG_LEAD:  lead_only_q <= cfg_i.data[0];
        tec_pkg::REG_TABW:  tab_width_q <= cfg_i.data[4:0];
        tec_pkg::REG_START: start_col_q <= cfg_i.data;
        default: ;
      endcase
      pend_q      <= 4'd0;
      lead_done_q <= 1'b0;
      busy_q      <= 1'b1;
      cnt_q       <= '0;
      rem_q       <= 4'd0;
      dvd_q       <= (cfg_i.idx == tec_pkg::REG_START) ? cfg_i.data : start_col_q;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[tec_pkg::START_W-2:0], 1'b0};
      rem_q <= rem_next[3:0];
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(tec_pkg::START_STEPS - 1)) begin
        busy_q        <= 1'b0;
        start_phase_q <= rem_next[3:0];
        phase_q       <= rem_next[3:0];
      end
    end else if (accept) begin
      phase_q     <= phase_d;
      pend_q      <= pend_d;
      lead_done_q <= lead_done_d;
    end
  end

  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.we |=> (busy_q && !in_ready_o))
    else $error("input not held off after a configuration write");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> ({1'b0, phase_q} < tw_eff))
    else $error("column phase outside the tab width");

  a_pend_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q && !busy_q) |-> ({1'b0, pend_q} < tw_eff))
    else $error("held spaces reach a tab stop");

endmodule

`default_nettype wire

// ----- rtl/tec_fifo.sv -----
// Short command queue between the front and back ends.
`default_nettype none

module tec_fifo #(
  parameter int unsigned DEPTH = tec_pkg::QDEPTH_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire tec_pkg::tec_cmd_t wdata_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output tec_pkg::tec_cmd_t      rdata_o,
  output logic                   empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  tec_pkg::tec_cmd_t mem_q [DEPTH];
  logic [AW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]     count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("command pushed into a full queue");

endmodule

`default_nettype wire

// ----- rtl/tec_back.sv -----
// Back end: plays out each command as output beats through a registered stage.
`default_nettype none

module tec_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire tec_pkg::tec_cmd_t q_data_i,
  input  wire logic              q_empty_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [15:0]            out_char_o,
  output logic                   out_last_o
);

  logic        cmd_vld_q;
  logic [4:0]  rem_q;
  logic        fin_vld_q, last_q;
  logic [15:0] fin_q;
  logic        out_vld_q, out_last_q;
  logic [15:0] out_char_q;
  logic        ld, emit, fin_step, done;

  assign ld       = !out_vld_q || out_ready_i;
  assign emit     = ld && cmd_vld_q;
  assign fin_step = (rem_q == 5'd0) || ((rem_q == 5'd1) && !fin_vld_q);
  assign done     = emit && fin_step;
  assign q_pop_o  = !q_empty_i && (!cmd_vld_q || done);

  assign out_valid_o = out_vld_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (emit) begin
        out_vld_q <= 1'b1;
      end else if (ld) begin
        out_vld_q <= 1'b0;
      end
      if (q_pop_o) begin
        cmd_vld_q <= 1'b1;
      end else if (done) begin
        cmd_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_char_q <= (rem_q != 5'd0) ? tec_pkg::CH_SPACE : fin_q;
      out_last_q <= fin_step && last_q;
    end
    if (q_pop_o) begin
      rem_q     <= q_data_i.spaces;
      fin_vld_q <= q_data_i.has_fin;
      fin_q     <= q_data_i.fin_char;
      last_q    <= q_data_i.last;
    end else if (emit && (rem_q != 5'd0)) begin
      rem_q <= rem_q - 5'd1;
    end
  end

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_vld_q |-> ((rem_q <= 5'd16) && ((rem_q != 5'd0) || fin_vld_q)))
    else $error("back end holds an empty or oversized command");

endmodule

`default_nettype wire

// ----- dv/tab_expand_compress_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the tab expand and compress block with its own line predictor.
module tab_expand_compress_top_tb;
  import tec_pkg::*;

  localparam int unsigned TAB_LIMIT   = TAB_MAX_DEF;
  localparam int unsigned MAX_BEATS   = 16;
  localparam int unsigned RAND_ITEMS  = 430;
  localparam int unsigned SETTLE_CYC  = 16;
  localparam int unsigned TIMEOUT_NS  = 10_000_000;

  localparam logic [15:0] CH_NUL = 16'h0000;
  localparam logic [15:0] CH_A   = 16'h0041;
  localparam logic [15:0] CH_MAX = 16'hFFFF;

  typedef struct packed {
    logic [15:0] ch;
    logic        last;
  } out_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  reg_idx_e    cfg_idx_i = REG_MODE;
  logic [11:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b1;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;

  // Mirror of the registers and of the per-line state.
  logic        cfg_compress;
  logic        cfg_leading;
  logic [4:0]  cfg_tab_width;
  logic [11:0] cfg_start_col;
  int unsigned col_phase;
  int unsigned held_spaces;
  bit          lead_done;

  out_beat_t   expected_beats[$];
  out_beat_t   item_beats[$];
  out_beat_t   head_beat;

  int unsigned items_sent;
  int unsigned beats_seen = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned settings_cnt;
  int unsigned burst_left;
  int unsigned rdy_left = 0;
  bit          gaps_on;
  bit          stalls_on;

  tab_expand_compress_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  function automatic int unsigned stop_width();
    int unsigned w;
    w = cfg_tab_width;
    if (w < 1) w = 1;
    if (w > TAB_LIMIT) w = TAB_LIMIT;
    if (w > MAX_BEATS) w = MAX_BEATS;
    return w;
  endfunction

  function automatic void restart_line();
    col_phase   = cfg_start_col % stop_width();
    held_spaces = 0;
    lead_done   = 1'b0;
  endfunction

  function automatic void add_beat(input logic [15:0] ch);
    out_beat_t b;
    b.ch   = ch;
    b.last = 1'b0;
    if (item_beats.size() < MAX_BEATS) item_beats.push_back(b);
  endfunction

  function automatic void flush_held();
    while (held_spaces > 0) begin
      add_beat(CH_SPACE);
      held_spaces--;
    end
  endfunction

  // Works out the output characters of one input character and queues them.
  function automatic void predict_line_chars(input logic [15:0] ch, input logic eol);
    int unsigned w;
    out_beat_t   b;
    w = stop_width();
    if (cfg_leading && lead_done) begin
      add_beat(ch);
      if (ch == CH_TAB) col_phase = 0;
      else col_phase = (col_phase + 1) % w;
    end else if (ch == CH_TAB) begin
      if (!cfg_compress) begin
        for (int unsigned k = col_phase; k < w; k++) add_beat(CH_SPACE);
      end else begin
        add_beat(CH_TAB);
      end
      col_phase   = 0;
      held_spaces = 0;
    end else if (ch == CH_SPACE) begin
      col_phase = (col_phase + 1) % w;
      if (!cfg_compress) begin
        add_beat(CH_SPACE);
      end else begin
        held_spaces++;
        if (col_phase == 0) begin
          add_beat(CH_TAB);
          held_spaces = 0;
        end
      end
    end else begin
      flush_held();
      add_beat(ch);
      col_phase = (col_phase + 1) % w;
      if (cfg_leading) lead_done = 1'b1;
    end
    if (eol) begin
      flush_held();
      if (item_beats.size() > 0) begin
        b = item_beats.pop_back();
        b.last = 1'b1;
        item_beats.push_back(b);
      end
      restart_line();
    end
    foreach (item_beats[i]) expected_beats.push_back(item_beats[i]);
    item_beats.delete();
  endfunction

  // Called at a rising edge; returns at the edge where the beat was taken, or after an idle gap that follows it.
  task automatic send_char(input logic [15:0] ch, input logic eol);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= eol;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_line_chars(ch, eol);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (gaps_on && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    // Characters that give no output may still be in flight.
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [11:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MODE:  cfg_compress  = val[0];
      REG_LEAD:  cfg_leading   = val[0];
      REG_TABW:  cfg_tab_width = val[4:0];
      REG_START: cfg_start_col = val;
      default: ;
    endcase
    restart_line();
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] body_char();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0, 1:    return CH_SPACE;
      2:       return CH_TAB;
      // Near misses of the two whitespace codes catch partial decoding.
      3:       return CH_TAB ^ (16'h0001 << r[3:0]);
      4:       return CH_SPACE ^ (16'h0001 << r[3:0]);
      5:       return r[15:0];
      default: return 16'h0021 + (r[15:0] % 16'd94);
    endcase
  endfunction

  task automatic send_random_line();
    int unsigned lead_len;
    int unsigned body_len;
    int unsigned n;
    logic [15:0] ch;
    lead_len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 34) : $urandom_range(0, 10);
    body_len = $urandom_range(0, 24);
    n = lead_len + body_len;
    if (n == 0) n = 1;
    for (int unsigned i = 0; i < n; i++) begin
      if (i < lead_len) ch = ($urandom_range(0, 2) == 0) ? CH_TAB : CH_SPACE;
      else ch = body_char();
      send_char(ch, i == n - 1);
    end
  endtask

  task automatic test_expand_tabs();
    // Register defaults after reset: expand, tab width 4, start column 0.
    send_char(CH_A, 1'b0);
    send_char(CH_TAB, 1'b0);
    send_char(CH_NUL, 1'b0);
    send_char(CH_TAB, 1'b1);
    wait_drained();
    // A width above the limit saturates, and the start column sits one short of a stop.
    write_reg(REG_TABW, 12'd31);
    write_reg(REG_START, 12'd4095);
    send_char(CH_TAB, 1'b0);
    send_char(CH_MAX, 1'b0);
    send_char(CH_TAB, 1'b1);
    wait_drained();
    write_reg(REG_TABW, 12'd0);
    send_char(CH_TAB, 1'b1);
    wait_drained();
    settings_cnt += 3;
  endtask

  task automatic test_compress_runs();
    write_reg(REG_TABW, 12'd4);
    write_reg(REG_START, 12'd0);
    write_reg(REG_MODE, 12'd1);
    send_char(CH_SPACE, 1'b0);
    send_char(CH_SPACE, 1'b0);
    send_char(CH_A, 1'b0);
    send_char(CH_SPACE, 1'b0);
    send_char(CH_SPACE, 1'b0);
    send_char(CH_TAB, 1'b0);
    send_char(CH_SPACE, 1'b0);
    send_char(CH_SPACE, 1'b1);
    wait_drained();
    write_reg(REG_TABW, 12'd1);
    send_char(CH_SPACE, 1'b1);
    wait_drained();
    settings_cnt += 2;
  endtask

  task automatic test_leading_only();
    write_reg(REG_TABW, 12'd4);
    write_reg(REG_LEAD, 12'd1);
    send_char(CH_SPACE, 1'b0);
    send_char(CH_TAB, 1'b0);
    send_char(CH_A, 1'b0);
    send_char(CH_SPACE, 1'b0);
    send_char(CH_TAB, 1'b1);
    wait_drained();
    settings_cnt++;
  endtask

  task automatic test_random_lines();
    int unsigned first_item;
    int unsigned target;
    int unsigned phase;
    logic [11:0] junk;
    logic [11:0] tw;
    logic [11:0] sc;
    logic        mode_bit;
    logic        lead_bit;
    first_item = items_sent;
    phase = 0;
    while (items_sent - first_item < RAND_ITEMS) begin
      gaps_on   = (phase % 4 != 1);
      stalls_on = (phase % 4 != 1);
      mode_bit  = (phase < 4) ? phase[0] : 1'($urandom_range(0, 1));
      lead_bit  = (phase < 4) ? phase[1] : 1'($urandom_range(0, 1));
      case ($urandom_range(0, 7))
        0:       tw = 12'd0;
        1:       tw = 12'd1;
        2:       tw = 12'd16;
        3:       tw = 12'd31;
        default: tw = 12'($urandom_range(2, 15));
      endcase
      case ($urandom_range(0, 3))
        0:       sc = 12'd0;
        1:       sc = 12'd4095;
        default: sc = 12'($urandom_range(0, 4095));
      endcase
      // Unused upper bits of the data word must not matter.
      junk = $urandom_range(0, 1) ? 12'($urandom) : 12'd0;
      write_reg(REG_MODE, {junk[11:1], mode_bit});
      write_reg(REG_LEAD, {junk[11:1], lead_bit});
      write_reg(REG_TABW, {junk[11:5], tw[4:0]});
      write_reg(REG_START, sc);
      settings_cnt++;
      target = items_sent + $urandom_range(40, 80);
      while (items_sent < target) send_random_line();
      // An unfinished run of spaces is dropped by the next register write.
      if ($urandom_range(0, 1)) begin
        repeat ($urandom_range(1, 5)) send_char(CH_SPACE, 1'b0);
      end
      wait_drained();
      phase++;
    end
  endtask

  // Receiver: ready and stalled stretches of random length while stalls are on, else always ready.
  always @(posedge clk_i) begin
    if (!stalls_on) begin
      m_axis_tready <= 1'b1;
    end else if (rdy_left != 0) begin
      rdy_left <= rdy_left - 1;
    end else if (m_axis_tready) begin
      m_axis_tready <= 1'b0;
      rdy_left      <= $urandom_range(0, 4);
    end else begin
      m_axis_tready <= 1'b1;
      rdy_left      <= $urandom_range(0, 9);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      beats_seen++;
      if (expected_beats.size() == 0) begin
        mismatch_cnt++;
        $display("%0t: output beat expected none actual char=%h last=%b", $time,
                 m_axis_tdata, m_axis_tlast);
      end else begin
        head_beat = expected_beats.pop_front();
        if (m_axis_tdata !== head_beat.ch) begin
          mismatch_cnt++;
          $display("%0t: char_out expected %h actual %h", $time, head_beat.ch, m_axis_tdata);
        end
        if (m_axis_tlast !== head_beat.last) begin
          mismatch_cnt++;
          $display("%0t: last_out expected %b actual %b", $time, head_beat.last,
                   m_axis_tlast);
        end
      end
    end
  end

  initial begin
    items_sent    = 0;
    settings_cnt  = 1;
    burst_left    = 0;
    gaps_on       = 1'b1;
    stalls_on     = 1'b1;
    cfg_compress  = 1'b0;
    cfg_leading   = 1'b0;
    cfg_tab_width = 5'd4;
    cfg_start_col = 12'd0;
    restart_line();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_expand_tabs();
    test_compress_runs();
    test_leading_only();
    test_random_lines();
    wait_drained();
    $display("Sent %0d characters under %0d register settings, checked %0d output characters.",
             items_sent, settings_cnt, beats_seen);
    $display("Expand, compress and leading-only lines ran with widths 0 to 31 and odd starts.");
    if (mismatch_cnt == 0 && expected_beats.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d output characters outstanding.", expected_beats.size());
    $display("FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/tec_pkg.sv
rtl/tec_front.sv
rtl/tec_fifo.sv
rtl/tec_back.sv
rtl/tab_expand_compress_top.sv
dv/tab_expand_compress_top_tb.sv
